// File: hw/rtl/plb_pkg.sv
`timescale 1ns / 1ps

package plb_pkg;

  localparam int LEVELS_DEF = 64;
  localparam int MAX_OUT    = 64;
  localparam int PW         = 64;
  localparam int QW         = 64;
  localparam int CNTW       = 7;
  localparam int STW        = 3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REDUCE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TOP    = 2'd3
  } op_t;

  localparam logic [STW-1:0] ST_OK        = 3'd0;
  localparam logic [STW-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STW-1:0] ST_FULL      = 3'd3;
  localparam logic [STW-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } act_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    act_t act;
    logic tap_load;
    logic tap_top;
    logic shift;
    logic shift_up;
  } cell_ctl_t;

endpackage

// File: hw/rtl/plb_cell.sv
`timescale 1ns / 1ps

module plb_cell #(
  parameter int LEVELS = plb_pkg::LEVELS_DEF,
  parameter int IDX    = 0,
  parameter int CW     = $clog2(LEVELS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmp_en,
  input  plb_pkg::cell_ctl_t         ctl,
  input  logic [plb_pkg::PW-1:0]     key_price,
  input  logic [plb_pkg::QW-1:0]     key_qty,
  input  logic                       key_sub,
  input  logic [CW-1:0]              level_count,
  input  logic [plb_pkg::CNTW-1:0]   read_n,
  input  logic                       bid,
  input  logic [plb_pkg::PW-1:0]     lo_price,
  input  logic [plb_pkg::QW-1:0]     lo_qty,
  input  logic                       lo_lt,
  input  logic [plb_pkg::PW-1:0]     lo_tap_price,
  input  logic [plb_pkg::QW-1:0]     lo_tap_qty,
  input  logic                       lo_tap_flag,
  input  logic [plb_pkg::PW-1:0]     hi_price,
  input  logic [plb_pkg::QW-1:0]     hi_qty,
  input  logic [plb_pkg::PW-1:0]     hi_tap_price,
  input  logic [plb_pkg::QW-1:0]     hi_tap_qty,
  input  logic                       hi_tap_flag,
  output logic [plb_pkg::PW-1:0]     price,
  output logic [plb_pkg::QW-1:0]     qty,
  output logic                       lt,
  output logic                       eq_hit,
  output logic                       ovf_hit,
  output logic                       zero_hit,
  output logic [plb_pkg::PW-1:0]     tap_price,
  output logic [plb_pkg::QW-1:0]     tap_qty,
  output logic                       tap_flag
);

  localparam int RW = CW + plb_pkg::CNTW + 1;
  localparam logic [CW-1:0] IDX_V  = CW'(IDX);
  localparam logic [RW-1:0] IDX_RW = RW'(IDX);

  logic                    valid;
  logic [plb_pkg::QW-1:0]  operand;
  logic [plb_pkg::QW-1:0]  res_c;
  logic                    ovf_c;
  logic                    eq;
  logic                    ovf;
  logic                    zero;
  logic [plb_pkg::QW-1:0]  res;
  logic [plb_pkg::PW-1:0]  price_next;
  logic [plb_pkg::QW-1:0]  qty_next;
  logic                    in_top;

  assign valid   = IDX_V < level_count;
  assign operand = key_sub ? ~key_qty : key_qty;
  assign res_c   = qty + operand + plb_pkg::QW'(key_sub);
  // operands of the effective add share a sign that the result lacks
  assign ovf_c   = ~(qty[plb_pkg::QW-1] ^ operand[plb_pkg::QW-1]) &
                   (qty[plb_pkg::QW-1] ^ res_c[plb_pkg::QW-1]);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt   <= valid && ($signed(price) < $signed(key_price));
      eq   <= valid && (price == key_price);
      res  <= res_c;
      ovf  <= ovf_c;
      zero <= (res_c == '0);
    end
  end

  assign eq_hit   = eq;
  assign ovf_hit  = eq & ovf;
  assign zero_hit = eq & zero;

  always_comb begin
    price_next = price;
    qty_next   = qty;
    unique case (ctl.act)
      plb_pkg::ACT_HOLD: begin
      end
      plb_pkg::ACT_UPDATE: begin
        if (eq) qty_next = res;
      end
      plb_pkg::ACT_INSERT: begin
        if (!lt) begin
          if (lo_lt) begin
            price_next = key_price;
            qty_next   = key_qty;
          end else begin
            price_next = lo_price;
            qty_next   = lo_qty;
          end
        end
      end
      plb_pkg::ACT_REMOVE: begin
        if (!lt) begin
          price_next = hi_price;
          qty_next   = hi_qty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price <= price_next;
    qty   <= qty_next;
  end

  // best levels: the top read_n valid slots for bid, the bottom ones for ask
  assign in_top = valid && (bid ? (IDX_RW + RW'(read_n) >= RW'(level_count))
                                : (IDX_RW < RW'(read_n)));

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_flag <= 1'b0;
    end else if (ctl.tap_load) begin
      tap_flag <= ctl.tap_top ? in_top : eq;
    end else if (ctl.shift) begin
      tap_flag <= ctl.shift_up ? lo_tap_flag : hi_tap_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_load) begin
      tap_price <= price_next;
      tap_qty   <= qty_next;
    end else if (ctl.shift) begin
      tap_price <= ctl.shift_up ? lo_tap_price : hi_tap_price;
      tap_qty   <= ctl.shift_up ? lo_tap_qty : hi_tap_qty;
    end
  end

endmodule

// File: hw/rtl/price_level_book_side_unit.sv
`timescale 1ns / 1ps

// One side of an order book: a price-sorted row of level cells.
// Input: present op, price, quantity and count with start; the word is taken
// on a clock edge where start is high and busy is low. busy stays high until
// the item has finished its work.
// Config: cfg_write with cfg_data sets bid_side (1 bid, best is highest price;
// 0 ask, best is lowest). Write it only while busy is low.
// Output: each result word shows on level_price, level_quantity, last and
// status for exactly one cycle with strobe high; last marks the final word of
// an item. The receiver cannot stall the block.
// Flow: every item first compares in all cells (S_CMP), then applies the
// change (S_APPLY). Results that need no data from a cell (new level,
// not found, full, removal, absent query, empty read) are registered in
// S_APPLY. Results that carry a cell's quantity, and read top, travel down
// the cell row's readout chain (S_DRAIN) one cell per cycle; after the
// first word the rest follow one word per cycle.
// Reset empties the table and selects the ask side; no clearing pass.
module price_level_book_side_unit #(
  parameter int LEVELS = plb_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic signed [plb_pkg::PW-1:0] price,
  input  logic signed [plb_pkg::QW-1:0] quantity,
  input  logic [plb_pkg::CNTW-1:0]   count,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  output logic                       strobe,
  output logic signed [plb_pkg::PW-1:0] level_price,
  output logic signed [plb_pkg::QW-1:0] level_quantity,
  output logic                       last,
  output logic [plb_pkg::STW-1:0]    status
);

  localparam int CW  = $clog2(LEVELS + 1);
  localparam int MW  = CW + plb_pkg::CNTW;
  localparam logic [CW-1:0] LEVELS_V = CW'(LEVELS);
  localparam logic [plb_pkg::CNTW-1:0] MAX_OUT_V = plb_pkg::CNTW'(plb_pkg::MAX_OUT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_APPLY = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t                    state;
  plb_pkg::op_t              op_r;
  logic [plb_pkg::PW-1:0]    price_r;
  logic [plb_pkg::QW-1:0]    qty_r;
  logic [plb_pkg::CNTW-1:0]  n_r;
  logic [CW-1:0]             level_count;
  logic                      bid_side;
  logic [plb_pkg::CNTW-1:0]  rem;
  logic [plb_pkg::STW-1:0]   drain_status;
  logic                      drain_up;

  logic [plb_pkg::CNTW-1:0]  cnt_sat;
  logic [plb_pkg::CNTW-1:0]  n_c;
  logic                      accept;

  plb_pkg::cell_ctl_t        ctl;
  logic                      found;
  logic                      ovf;
  logic                      zero;
  logic                      emit_direct;
  logic [plb_pkg::PW-1:0]    emit_price;
  logic [plb_pkg::QW-1:0]    emit_qty;
  logic [plb_pkg::STW-1:0]   emit_status;
  logic                      go_drain;
  logic [plb_pkg::CNTW-1:0]  rem_c;
  logic [plb_pkg::STW-1:0]   drain_status_c;
  logic                      inc;
  logic                      dec;
  logic                      end_flag;
  logic [plb_pkg::PW-1:0]    end_price;
  logic [plb_pkg::QW-1:0]    end_qty;

  logic [plb_pkg::PW-1:0]    c_price     [LEVELS];
  logic [plb_pkg::QW-1:0]    c_qty       [LEVELS];
  logic [plb_pkg::PW-1:0]    c_tap_price [LEVELS];
  logic [plb_pkg::QW-1:0]    c_tap_qty   [LEVELS];
  logic [LEVELS-1:0]         c_lt;
  logic [LEVELS-1:0]         c_eq;
  logic [LEVELS-1:0]         c_ovf;
  logic [LEVELS-1:0]         c_zero;
  logic [LEVELS-1:0]         c_tap_flag;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // read count: zero means one, capped at the result limit and the table fill
  always_comb begin
    if (count == '0) begin
      cnt_sat = plb_pkg::CNTW'(1);
    end else if (count > MAX_OUT_V) begin
      cnt_sat = MAX_OUT_V;
    end else begin
      cnt_sat = count;
    end
    if (MW'(level_count) < MW'(cnt_sat)) begin
      n_c = plb_pkg::CNTW'(level_count);
    end else begin
      n_c = cnt_sat;
    end
  end

  genvar g;
  generate
    for (g = 0; g < LEVELS; g++) begin : g_cell
      logic [plb_pkg::PW-1:0] lo_price, hi_price, lo_tap_price, hi_tap_price;
      logic [plb_pkg::QW-1:0] lo_qty, hi_qty, lo_tap_qty, hi_tap_qty;
      logic                   lo_lt, lo_tap_flag, hi_tap_flag;

      if (g == 0) begin : g_lo_edge
        assign lo_price     = '0;
        assign lo_qty       = '0;
        assign lo_lt        = 1'b1;
        assign lo_tap_price = '0;
        assign lo_tap_qty   = '0;
        assign lo_tap_flag  = 1'b0;
      end else begin : g_lo
        assign lo_price     = c_price[g-1];
        assign lo_qty       = c_qty[g-1];
        assign lo_lt        = c_lt[g-1];
        assign lo_tap_price = c_tap_price[g-1];
        assign lo_tap_qty   = c_tap_qty[g-1];
        assign lo_tap_flag  = c_tap_flag[g-1];
      end

      if (g == LEVELS - 1) begin : g_hi_edge
        assign hi_price     = '0;
        assign hi_qty       = '0;
        assign hi_tap_price = '0;
        assign hi_tap_qty   = '0;
        assign hi_tap_flag  = 1'b0;
      end else begin : g_hi
        assign hi_price     = c_price[g+1];
        assign hi_qty       = c_qty[g+1];
        assign hi_tap_price = c_tap_price[g+1];
        assign hi_tap_qty   = c_tap_qty[g+1];
        assign hi_tap_flag  = c_tap_flag[g+1];
      end

      plb_cell #(
        .LEVELS(LEVELS),
        .IDX   (g),
        .CW    (CW)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmp_en      (state == S_CMP),
        .ctl         (ctl),
        .key_price   (price_r),
        .key_qty     (qty_r),
        .key_sub     (op_r == plb_pkg::OP_REDUCE),
        .level_count (level_count),
        .read_n      (n_r),
        .bid         (bid_side),
        .lo_price    (lo_price),
        .lo_qty      (lo_qty),
        .lo_lt       (lo_lt),
        .lo_tap_price(lo_tap_price),
        .lo_tap_qty  (lo_tap_qty),
        .lo_tap_flag (lo_tap_flag),
        .hi_price    (hi_price),
        .hi_qty      (hi_qty),
        .hi_tap_price(hi_tap_price),
        .hi_tap_qty  (hi_tap_qty),
        .hi_tap_flag (hi_tap_flag),
        .price       (c_price[g]),
        .qty         (c_qty[g]),
        .lt          (c_lt[g]),
        .eq_hit      (c_eq[g]),
        .ovf_hit     (c_ovf[g]),
        .zero_hit    (c_zero[g]),
        .tap_price   (c_tap_price[g]),
        .tap_qty     (c_tap_qty[g]),
        .tap_flag    (c_tap_flag[g])
      );
    end
  endgenerate

  assign found = |c_eq;
  assign ovf   = |c_ovf;
  assign zero  = |c_zero;

  // decide the change and where the result comes from
  always_comb begin
    ctl            = '{act: plb_pkg::ACT_HOLD, tap_load: 1'b0, tap_top: 1'b0,
                       shift: 1'b0, shift_up: 1'b0};
    emit_direct    = 1'b0;
    emit_price     = price_r;
    emit_qty       = '0;
    emit_status    = plb_pkg::ST_OK;
    go_drain       = 1'b0;
    rem_c          = plb_pkg::CNTW'(1);
    drain_status_c = plb_pkg::ST_OK;
    inc            = 1'b0;
    dec            = 1'b0;
    if (state == S_APPLY) begin
      unique case (op_r)
        plb_pkg::OP_ADD: begin
          if (found) begin
            ctl.tap_load   = 1'b1;
            go_drain       = 1'b1;
            if (ovf) begin
              drain_status_c = plb_pkg::ST_OVERFLOW;
            end else begin
              ctl.act = plb_pkg::ACT_UPDATE;
            end
          end else if (level_count == LEVELS_V) begin
            emit_direct = 1'b1;
            emit_status = plb_pkg::ST_FULL;
          end else begin
            ctl.act     = plb_pkg::ACT_INSERT;
            emit_direct = 1'b1;
            emit_qty    = qty_r;
            inc         = 1'b1;
          end
        end
        plb_pkg::OP_REDUCE: begin
          if (!found) begin
            emit_direct = 1'b1;
            emit_status = plb_pkg::ST_NOT_FOUND;
          end else if (ovf) begin
            ctl.tap_load   = 1'b1;
            go_drain       = 1'b1;
            drain_status_c = plb_pkg::ST_OVERFLOW;
          end else if (zero) begin
            ctl.act     = plb_pkg::ACT_REMOVE;
            emit_direct = 1'b1;
            dec         = 1'b1;
          end else begin
            ctl.act      = plb_pkg::ACT_UPDATE;
            ctl.tap_load = 1'b1;
            go_drain     = 1'b1;
          end
        end
        plb_pkg::OP_QUERY: begin
          if (found) begin
            ctl.tap_load = 1'b1;
            go_drain     = 1'b1;
          end else begin
            emit_direct = 1'b1;
          end
        end
        plb_pkg::OP_TOP: begin
          if (level_count == '0) begin
            emit_direct = 1'b1;
            emit_price  = '0;
            emit_status = plb_pkg::ST_EMPTY;
          end else begin
            ctl.tap_load = 1'b1;
            ctl.tap_top  = 1'b1;
            go_drain     = 1'b1;
            rem_c        = n_r;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_DRAIN) begin
      ctl.shift    = 1'b1;
      ctl.shift_up = drain_up;
    end
  end

  assign end_flag  = drain_up ? c_tap_flag[LEVELS-1] : c_tap_flag[0];
  assign end_price = drain_up ? c_tap_price[LEVELS-1] : c_tap_price[0];
  assign end_qty   = drain_up ? c_tap_qty[LEVELS-1] : c_tap_qty[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_count <= '0;
      bid_side    <= 1'b0;
      rem         <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_write) bid_side <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_CMP;
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (inc) level_count <= level_count + CW'(1);
          if (dec) level_count <= level_count - CW'(1);
          if (go_drain) begin
            rem   <= rem_c;
            state <= S_DRAIN;
          end else begin
            strobe <= emit_direct;
            state  <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (end_flag) begin
            strobe <= 1'b1;
            rem    <= rem - plb_pkg::CNTW'(1);
            if (rem == plb_pkg::CNTW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= plb_pkg::op_t'(op);
      price_r <= price;
      qty_r   <= quantity;
      n_r     <= n_c;
    end
    if (state == S_APPLY) begin
      drain_status <= drain_status_c;
      drain_up     <= (op_r == plb_pkg::OP_TOP) && bid_side;
      level_price    <= emit_price;
      level_quantity <= emit_qty;
      status         <= emit_status;
      last           <= 1'b1;
    end else if (state == S_DRAIN && end_flag) begin
      level_price    <= end_price;
      level_quantity <= end_qty;
      status         <= drain_status;
      last           <= (rem == plb_pkg::CNTW'(1));
    end
  end

  a_drain_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (rem != '0))
    else $error("draining with no results left");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    level_count <= LEVELS_V)
    else $error("level count beyond table size");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (state == S_DRAIN))
    else $error("non-final word with no item in progress");

  a_apply_yields: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |=> (strobe || state == S_DRAIN))
    else $error("item finished without a result");

  a_idle_table_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (level_count == $past(level_count)))
    else $error("table fill changed while idle");

endmodule

// File: tb/price_level_book_side_unit_tb.sv
`timescale 1ns / 1ps

module price_level_book_side_unit_tb;

  localparam int BOOK_LEVELS = plb_pkg::LEVELS_DEF;
  localparam int POOL_SIZE   = 96;
  localparam int QUIET_LIMIT = 2000;
  localparam logic signed [63:0] P_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] P_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    plb_pkg::op_t              op;
    logic signed [63:0]        price;
    logic signed [63:0]        qty;
    logic [plb_pkg::CNTW-1:0]  count;
    bit                        take_all;  // reduce by whatever the level holds now
  } order_t;

  typedef struct {
    logic signed [63:0]       price;
    logic signed [63:0]       qty;
    logic                     last;
    logic [plb_pkg::STW-1:0]  status;
  } level_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [1:0]                     op = plb_pkg::OP_QUERY;
  logic signed [plb_pkg::PW-1:0]  price = '0;
  logic signed [plb_pkg::QW-1:0]  quantity = '0;
  logic [plb_pkg::CNTW-1:0]       count = '0;
  logic                           cfg_write = 1'b0;
  logic                           cfg_data = 1'b0;
  logic                           strobe;
  logic signed [plb_pkg::PW-1:0]  level_price;
  logic signed [plb_pkg::QW-1:0]  level_quantity;
  logic                           last;
  logic [plb_pkg::STW-1:0]        status;

  // Predicted book state
  logic signed [63:0] book_px  [BOOK_LEVELS];
  logic signed [63:0] book_qty [BOOK_LEVELS];
  int                 book_depth = 0;
  logic               book_bid = 1'b0;

  order_t             order_queue[$];
  level_word_t        pending_words[$];
  order_t             cur_order;
  logic signed [63:0] price_pool [POOL_SIZE];

  int errors = 0;
  int orders_taken = 0;
  int words_checked = 0;
  int status_seen [5];
  int gap_left = 0;
  bit burst_mode = 1'b0;
  int quiet = 0;

  price_level_book_side_unit #(.LEVELS(BOOK_LEVELS)) u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .price          (price),
    .quantity       (quantity),
    .count          (count),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .level_price    (level_price),
    .level_quantity (level_quantity),
    .last           (last),
    .status         (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void note_word(logic signed [63:0] p, logic signed [63:0] q,
                                    logic l, logic [plb_pkg::STW-1:0] st);
    level_word_t w;
    w.price  = p;
    w.qty    = q;
    w.last   = l;
    w.status = st;
    pending_words = {pending_words, w};
  endfunction

  function automatic logic signed [63:0] level_qty_of(logic signed [63:0] p);
    for (int i = 0; i < book_depth; i++)
      if (book_px[i] == p) return book_qty[i];
    return '0;
  endfunction

  // Apply one order to the predicted book and queue the words it yields.
  task automatic book_apply(input order_t o);
    int                 i;
    int                 n;
    int                 s;
    bit                 found;
    logic signed [63:0] cur;
    logic signed [63:0] res;
    i = 0;
    while (i < book_depth && book_px[i] < o.price) i++;
    found = (i < book_depth) && (book_px[i] == o.price);
    case (o.op)
      plb_pkg::OP_ADD: begin
        if (found) begin
          cur = book_qty[i];
          res = cur + o.qty;
          if (cur[63] == o.qty[63] && res[63] != cur[63]) begin
            note_word(o.price, cur, 1'b1, plb_pkg::ST_OVERFLOW);
          end else begin
            book_qty[i] = res;
            note_word(o.price, res, 1'b1, plb_pkg::ST_OK);
          end
        end else if (book_depth >= BOOK_LEVELS) begin
          note_word(o.price, '0, 1'b1, plb_pkg::ST_FULL);
        end else begin
          for (int j = book_depth; j > i; j--) begin
            book_px[j]  = book_px[j-1];
            book_qty[j] = book_qty[j-1];
          end
          book_px[i]  = o.price;
          book_qty[i] = o.qty;
          book_depth++;
          note_word(o.price, o.qty, 1'b1, plb_pkg::ST_OK);
        end
      end
      plb_pkg::OP_REDUCE: begin
        if (!found) begin
          note_word(o.price, '0, 1'b1, plb_pkg::ST_NOT_FOUND);
        end else begin
          cur = book_qty[i];
          res = cur - o.qty;
          if (cur[63] != o.qty[63] && res[63] != cur[63]) begin
            note_word(o.price, cur, 1'b1, plb_pkg::ST_OVERFLOW);
          end else if (res == 0) begin
            for (int j = i; j < book_depth - 1; j++) begin
              book_px[j]  = book_px[j+1];
              book_qty[j] = book_qty[j+1];
            end
            book_depth--;
            note_word(o.price, '0, 1'b1, plb_pkg::ST_OK);
          end else begin
            book_qty[i] = res;
            note_word(o.price, res, 1'b1, plb_pkg::ST_OK);
          end
        end
      end
      plb_pkg::OP_QUERY: begin
        note_word(o.price, found ? book_qty[i] : '0, 1'b1, plb_pkg::ST_OK);
      end
      default: begin
        if (book_depth == 0) begin
          note_word('0, '0, 1'b1, plb_pkg::ST_EMPTY);
        end else begin
          n = o.count;
          if (n == 0) n = 1;
          if (n > plb_pkg::MAX_OUT) n = plb_pkg::MAX_OUT;
          if (n > book_depth) n = book_depth;
          for (int k = 0; k < n; k++) begin
            s = book_bid ? (book_depth - 1 - k) : k;
            note_word(book_px[s], book_qty[s], (k == n - 1), plb_pkg::ST_OK);
          end
        end
      end
    endcase
  endtask

  // Driver: present the next order once the previous word is taken.
  always @(posedge clk) begin : drive
    order_t nxt;
    logic   next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        book_apply(cur_order);
        orders_taken++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (order_queue.size() != 0) begin
          nxt = order_queue.pop_front();
          if (nxt.take_all) nxt.qty = level_qty_of(nxt.price);
          cur_order = nxt;
          op         <= nxt.op;
          price      <= nxt.price;
          quantity   <= nxt.qty;
          count      <= nxt.count;
          next_start = 1'b1;
          if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
          gap_left = burst_mode ? 0 : $urandom_range(0, 16);
        end
      end
      start <= next_start;
    end
  end

  task automatic check_field(string name, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin : watch
    level_word_t w;
    if (!rst && strobe) begin
      if (status <= plb_pkg::ST_EMPTY) status_seen[status]++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual price %0d qty %0d status %0d",
                 $time, level_price, level_quantity, status);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        check_field("level_price", w.price, level_price);
        check_field("level_quantity", w.qty, level_quantity);
        check_field("last", w.last, last);
        check_field("status", w.status, status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin : watchdog
    wait (quiet >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic push_order(plb_pkg::op_t o, logic signed [63:0] p,
                            logic signed [63:0] q, logic [plb_pkg::CNTW-1:0] c,
                            bit all = 1'b0);
    order_t t;
    t.op       = o;
    t.price    = p;
    t.qty      = q;
    t.count    = c;
    t.take_all = all;
    order_queue = {order_queue, t};
  endtask

  function automatic logic signed [63:0] rand_qty();
    case ($urandom_range(0, 11))
      0:       return P_MAX;
      1:       return P_MIN;
      2:       return {$urandom, $urandom};
      3:       return -64'sd1;
      default: return $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
    endcase
  endfunction

  function automatic logic [plb_pkg::CNTW-1:0] rand_count();
    if ($urandom_range(0, 3) == 0) return plb_pkg::CNTW'($urandom_range(0, 127));
    return plb_pkg::CNTW'($urandom_range(1, 8));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (order_queue.size() != 0 || start || pending_words.size() != 0 || busy);
  endtask

  task automatic set_side(logic v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    book_bid = v;
    @(negedge clk);
  endtask

  task automatic mixed_orders(int n);
    int                 r;
    logic signed [63:0] p;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) p = price_pool[$urandom_range(0, POOL_SIZE - 1)];
      else p = {$urandom, $urandom};
      if (r < 35)      push_order(plb_pkg::OP_ADD, p, rand_qty(), rand_count());
      else if (r < 65) push_order(plb_pkg::OP_REDUCE, p, rand_qty(), rand_count(),
                                  1'($urandom_range(0, 1)));
      else if (r < 80) push_order(plb_pkg::OP_QUERY, p, rand_qty(), rand_count());
      else             push_order(plb_pkg::OP_TOP, p, rand_qty(), rand_count());
    end
  endtask

  initial begin : stimulus
    for (int k = 0; k < POOL_SIZE; k++) begin
      if (k % 2 == 0) price_pool[k] = -64'sd2048 + 64'(k * 37 + $urandom_range(0, 36));
      else price_pool[k] = {$urandom, $urandom};
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_side(1'b0);

    // Directed: empty table, absent prices, extremes and overflow edges
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd5);
    push_order(plb_pkg::OP_REDUCE, 64'sd100, 64'sd1, 7'd1);
    push_order(plb_pkg::OP_QUERY, 64'sd100, 64'sd0, 7'd1);
    push_order(plb_pkg::OP_ADD, 64'sd100, 64'sd50, 7'd1);
    push_order(plb_pkg::OP_ADD, P_MIN, P_MAX, 7'd1);
    push_order(plb_pkg::OP_ADD, P_MAX, P_MIN, 7'd1);
    push_order(plb_pkg::OP_ADD, -64'sd1, 64'sd0, 7'd1);
    push_order(plb_pkg::OP_ADD, 64'sd100, P_MAX, 7'd1);
    push_order(plb_pkg::OP_ADD, P_MIN, 64'sd1, 7'd1);
    push_order(plb_pkg::OP_ADD, P_MAX, -64'sd1, 7'd1);
    push_order(plb_pkg::OP_REDUCE, P_MAX, 64'sd1, 7'd1);
    push_order(plb_pkg::OP_REDUCE, P_MIN, -64'sd1, 7'd1);
    push_order(plb_pkg::OP_QUERY, P_MIN, 64'sd0, 7'd1);
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd0);
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd127);
    push_order(plb_pkg::OP_REDUCE, -64'sd1, 64'sd0, 7'd1);
    push_order(plb_pkg::OP_REDUCE, 64'sd100, 64'sd20, 7'd1);
    push_order(plb_pkg::OP_REDUCE, 64'sd100, 64'sd30, 7'd1);
    push_order(plb_pkg::OP_QUERY, 64'sd100, 64'sd0, 7'd1);
    push_order(plb_pkg::OP_ADD, 64'sd0, -64'sd5, 7'd1);
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd2);
    push_order(plb_pkg::OP_REDUCE, 64'sd0, -64'sd5, 7'd1);
    wait_idle();

    // Fill past capacity on the bid side, then read the whole book
    set_side(1'b1);
    for (int k = 0; k < 72; k++)
      push_order(plb_pkg::OP_ADD, price_pool[k], rand_qty(), rand_count());
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd64);
    push_order(plb_pkg::OP_TOP, 64'sd0, 64'sd0, 7'd127);
    wait_idle();

    set_side(1'b0);
    mixed_orders(95);
    wait_idle();

    set_side(1'b1);
    mixed_orders(95);
    wait_idle();

    repeat (BOOK_LEVELS + plb_pkg::MAX_OUT + 8) @(negedge clk);
    $display("Covered %0d orders and %0d words on both book sides, including a full book.",
             orders_taken, words_checked);
    $display("Status words: overflow %0d, not found %0d, full %0d, empty %0d.",
             status_seen[plb_pkg::ST_OVERFLOW], status_seen[plb_pkg::ST_NOT_FOUND],
             status_seen[plb_pkg::ST_FULL], status_seen[plb_pkg::ST_EMPTY]);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d words still outstanding", errors, pending_words.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
